FILE: design/sjpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjpg_pkg
// shared types, codes and constants of the stepper jog pulse generator
// ----------------------------------------------------------------------------
package sjpg_pkg;

  // fixed field widths
  localparam int CMD_W      = 4;
  localparam int STEPS_W    = 16;   // step counter width
  localparam int POS_W      = 32;   // position width
  localparam int RATE_W     = 16;
  localparam int TICK8_W    = 8;
  localparam int EVENT_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 24;
  localparam int S_USER_W   = 4;
  localparam int M_DATA_W   = 72;

  localparam int TICKS_PER_SECOND_DEF = 1000000;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CW      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CCW     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_JOG     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FASTER  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SLOWER  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ABORT   = 4'd8;

  // events
  localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
  localparam logic [EVENT_W-1:0] EV_REF_DISABLED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_REF_ENDSTOP  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_ENDSTOP_STOP = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ABORTED      = 3'd4;
  localparam logic [EVENT_W-1:0] EV_DONE         = 3'd5;
  localparam logic [EVENT_W-1:0] EV_IGNORED_BUSY = 3'd6;
  localparam logic [EVENT_W-1:0] EV_NO_ABORT     = 3'd7;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_LOW    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_HI_MIN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DIR_SETTLE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE_MIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE_MAX     = 3'd4;

  // reset values
  localparam logic [TICK8_W-1:0] PULSE_LOW_RST    = 8'd5;
  localparam logic [TICK8_W-1:0] PULSE_HI_MIN_RST = 8'd5;
  localparam logic [TICK8_W-1:0] DIR_SETTLE_RST   = 8'd10;
  localparam logic [RATE_W-1:0]  RATE_MIN_RST     = 16'd125;
  localparam logic [RATE_W-1:0]  RATE_MAX_RST     = 16'd20000;
  localparam logic [RATE_W-1:0]  STEP_RATE_RST    = 16'd1000;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the accepted word
    logic div_start;  // start the period divide
    logic apply;      // execute the item and load the result register
  } sjpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;   // latched item is a jog that will move
    logic div_done;   // period quotient ready
    logic out_free;   // result register can take a word this cycle
  } sjpg_stat_t;

endpackage : sjpg_pkg
`default_nettype wire

FILE: design/sjpg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjpg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sjpg_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits the low bits
      rem      <= fits ? DIVISOR_W'(shifted - {1'b0, dvs}) : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule : sjpg_div
`default_nettype wire

FILE: design/sjpg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjpg_ctrl
// sequencing state machine: accept, check, divide, execute
// ----------------------------------------------------------------------------
module sjpg_ctrl
  import sjpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire sjpg_stat_t stat,
  output sjpg_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.apply     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule : sjpg_ctrl
`default_nettype wire

FILE: design/sjpg_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjpg_dp
// datapath: configuration, motion state, period divider and result register
// ----------------------------------------------------------------------------
module sjpg_dp
  import sjpg_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [S_DATA_W-1:0]   s_tdata,
  input  wire logic [S_USER_W-1:0]   s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_DATA_W-1:0]        m_tdata,
  input  wire sjpg_cmd_t             cmd,
  output sjpg_stat_t                 stat
);

  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int HW    = (TPS_W > 17) ? TPS_W : 17;

  // configuration
  logic [TICK8_W-1:0] pulse_low;
  logic [TICK8_W-1:0] pulse_hi_min;
  logic [TICK8_W-1:0] dir_settle;
  logic [RATE_W-1:0]  rate_min;
  logic [RATE_W-1:0]  rate_max;

  // latched item
  logic [CMD_W-1:0]   item_cmd;
  logic [STEPS_W-1:0] item_steps;
  logic               item_endstop;

  // motion state
  logic               driver_on, clockwise, moving, in_low, abort_pend;
  logic [POS_W-1:0]   position;
  logic [RATE_W-1:0]  step_rate;
  logic [STEPS_W-1:0] target_steps, done_steps;
  logic [15:0]        phase_cnt, high_len;
  logic [TICK8_W-1:0] settle_cnt;

  logic               driver_on_next, clockwise_next, moving_next, in_low_next;
  logic               abort_pend_next;
  logic [POS_W-1:0]   position_next;
  logic [RATE_W-1:0]  step_rate_next;
  logic [STEPS_W-1:0] target_steps_next, done_steps_next;
  logic [15:0]        phase_cnt_next, high_len_next;
  logic [TICK8_W-1:0] settle_cnt_next;
  logic               lvl;
  logic [EVENT_W-1:0] ev;

  logic               busy;
  logic [RATE_W-1:0]  divisor;
  logic [TPS_W-1:0]   period;
  logic               div_done;
  logic [HW-1:0]      period_x, low_x, sum_x, high_x;
  logic [15:0]        high_calc;
  logic [RATE_W:0]    rate_dbl;
  logic [RATE_W-1:0]  rate_half;

  assign busy = moving || (settle_cnt != '0);

  // period divider, a rate of zero counts as one hertz
  assign divisor = (step_rate == '0) ? RATE_W'(1) : step_rate;

  sjpg_div #(
    .DIVIDEND_W (TPS_W),
    .DIVISOR_W  (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (TPS_W'(TICKS_PER_SECOND)),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (period)
  );

  // high phase: period minus low, at least the minimum, saturated to 16 bits
  always_comb begin
    period_x = HW'(period);
    low_x    = HW'(pulse_low);
    sum_x    = HW'(pulse_low) + HW'(pulse_hi_min);
    if (period_x > sum_x) high_x = period_x - low_x;
    else                  high_x = HW'(pulse_hi_min);
    high_calc = (high_x > HW'(16'hFFFF)) ? 16'hFFFF : high_x[15:0];
  end

  assign rate_dbl  = {step_rate, 1'b0};
  assign rate_half = step_rate >> 1;

  assign stat.need_div = (item_cmd == CMD_JOG) && !busy && driver_on && !item_endstop
                         && (item_steps != '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

  // item execution
  always_comb begin
    logic               fin;
    logic [EVENT_W-1:0] fin_ev;
    logic               low_e;
    logic [15:0]        pc_e;
    logic [15:0]        pc_dec;

    driver_on_next    = driver_on;
    clockwise_next    = clockwise;
    moving_next       = moving;
    in_low_next       = in_low;
    abort_pend_next   = abort_pend;
    position_next     = position;
    step_rate_next    = step_rate;
    target_steps_next = target_steps;
    done_steps_next   = done_steps;
    phase_cnt_next    = phase_cnt;
    high_len_next     = high_len;
    settle_cnt_next   = settle_cnt;
    lvl               = 1'b1;
    ev                = EV_NONE;
    fin               = 1'b0;
    fin_ev            = EV_NONE;
    low_e             = in_low;
    pc_e              = phase_cnt;
    pc_dec            = '0;

    if (item_cmd == CMD_TICK) begin
      if (settle_cnt != '0) begin
        settle_cnt_next = settle_cnt - 1'b1;
      end else if (moving) begin
        // step boundary checks
        if (!in_low && phase_cnt == '0) begin
          if (done_steps >= target_steps) begin
            fin = 1'b1; fin_ev = EV_DONE;
          end else if (item_endstop) begin
            fin = 1'b1; fin_ev = EV_ENDSTOP_STOP;
          end else if (abort_pend) begin
            fin = 1'b1; fin_ev = EV_ABORTED;
          end else begin
            low_e = 1'b1;
            pc_e  = (pulse_low == '0) ? 16'd1 : 16'(pulse_low);
          end
        end
        if (fin) begin
          ev              = fin_ev;
          position_next   = clockwise ? position + POS_W'(done_steps)
                                      : position - POS_W'(done_steps);
          moving_next     = 1'b0;
          in_low_next     = 1'b0;
          phase_cnt_next  = '0;
          abort_pend_next = 1'b0;
        end else begin
          lvl    = !low_e;
          pc_dec = pc_e - 1'b1;
          in_low_next    = low_e;
          phase_cnt_next = pc_dec;
          if (pc_dec == '0) begin
            if (low_e) begin
              in_low_next    = 1'b0;
              phase_cnt_next = (high_len == '0) ? 16'd1 : high_len;
            end else begin
              done_steps_next = done_steps + 1'b1;
            end
          end
        end
      end
    end else if (item_cmd == CMD_ABORT) begin
      if (moving) abort_pend_next = 1'b1;
      else        ev = EV_NO_ABORT;
    end else if (item_cmd inside {[CMD_ENABLE:CMD_SLOWER]} && busy) begin
      ev = EV_IGNORED_BUSY;
    end else begin
      case (item_cmd)
        CMD_ENABLE:  driver_on_next = 1'b1;
        CMD_DISABLE: driver_on_next = 1'b0;
        CMD_CW: begin
          clockwise_next  = 1'b1;
          settle_cnt_next = dir_settle;
        end
        CMD_CCW: begin
          clockwise_next  = 1'b0;
          settle_cnt_next = dir_settle;
        end
        CMD_JOG: begin
          if (!driver_on) begin
            ev = EV_REF_DISABLED;
          end else if (item_endstop) begin
            ev = EV_REF_ENDSTOP;
          end else begin
            target_steps_next = item_steps;
            done_steps_next   = '0;
            in_low_next       = 1'b0;
            phase_cnt_next    = '0;
            abort_pend_next   = 1'b0;
            if (item_steps == '0) begin
              // nothing to move, done at once
              ev = EV_DONE;
            end else begin
              high_len_next = high_calc;
              moving_next   = 1'b1;
            end
          end
        end
        CMD_FASTER: begin
          step_rate_next = (rate_dbl < {1'b0, rate_max}) ? rate_dbl[RATE_W-1:0] : rate_max;
        end
        CMD_SLOWER: begin
          step_rate_next = (rate_half > rate_min) ? rate_half : rate_min;
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_low    <= PULSE_LOW_RST;
      pulse_hi_min <= PULSE_HI_MIN_RST;
      dir_settle   <= DIR_SETTLE_RST;
      rate_min     <= RATE_MIN_RST;
      rate_max     <= RATE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PULSE_LOW:    pulse_low    <= cfg_wdata[TICK8_W-1:0];
        REG_PULSE_HI_MIN: pulse_hi_min <= cfg_wdata[TICK8_W-1:0];
        REG_DIR_SETTLE:   dir_settle   <= cfg_wdata[TICK8_W-1:0];
        REG_RATE_MIN:     rate_min     <= cfg_wdata;
        REG_RATE_MAX:     rate_max     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd     <= s_tuser;
      item_steps   <= s_tdata[STEPS_W-1:0];
      item_endstop <= s_tdata[STEPS_W];
    end
  end

  // motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      driver_on    <= 1'b0;
      clockwise    <= 1'b1;
      moving       <= 1'b0;
      in_low       <= 1'b0;
      abort_pend   <= 1'b0;
      position     <= '0;
      step_rate    <= STEP_RATE_RST;
      target_steps <= '0;
      done_steps   <= '0;
      phase_cnt    <= '0;
      high_len     <= '0;
      settle_cnt   <= '0;
    end else if (cmd.apply) begin
      driver_on    <= driver_on_next;
      clockwise    <= clockwise_next;
      moving       <= moving_next;
      in_low       <= in_low_next;
      abort_pend   <= abort_pend_next;
      position     <= position_next;
      step_rate    <= step_rate_next;
      target_steps <= target_steps_next;
      done_steps   <= done_steps_next;
      phase_cnt    <= phase_cnt_next;
      high_len     <= high_len_next;
      settle_cnt   <= settle_cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      m_tdata <= {1'b0, step_rate_next, position_next, done_steps_next, ev,
                  moving_next || (settle_cnt_next != '0),
                  !driver_on_next, !clockwise_next, lvl};
    end
  end

endmodule : sjpg_dp
`default_nettype wire

FILE: design/stepper_jog_pulse_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_jog_pulse_generator
// step/dir/enable pulse generator with active-low outputs, driven by ticks
// ----------------------------------------------------------------------------
// Each input word is a one-microsecond tick or a command (enable, disable,
// cw, ccw, jog, faster, slower, abort), and each one yields exactly one
// result word with the pin levels, busy flag, event code, step count,
// position and current rate. Words are taken one at a time: a tick or a
// command other than a moving jog passes through the check and execute
// states before its result is loaded; a jog that starts a move also waits
// on the bit-serial divide of TPS_W = clog2(TICKS_PER_SECOND+1) quotient
// bits that turns the rate into a step period. A stalled result register
// adds its stall time. The next word is accepted as soon as the previous
// result has been loaded, even while that result still waits on m_tready.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// and should only change while no word is in flight.
// ----------------------------------------------------------------------------
module stepper_jog_pulse_generator
  import sjpg_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF   // tick rate, 1e3 to 1e6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,    // register index
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_DATA_W-1:0]   s_tdata,     // jog_steps[15:0], endstop_level[16]
  input  wire logic [S_USER_W-1:0]   s_tuser,     // cmd[3:0]
  // result words
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_DATA_W-1:0]        m_tdata      // step_pin[0], dir_pin[1],
                                                  // enable_pin[2], busy_res[3],
                                                  // event_res[6:4],
                                                  // steps_taken[22:7],
                                                  // position[54:23],
                                                  // rate_hz[70:55]
);

  sjpg_cmd_t  ctrl_cmd;   // sequencing commands to the datapath
  sjpg_stat_t dp_stat;    // datapath status back to the sequencer

  // sequencer: accept, check for a moving jog, wait on divide, execute
  sjpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // datapath: registers, motion state, divider and result register
  sjpg_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat)
  );

endmodule : stepper_jog_pulse_generator
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the stepper jog pulse generator
// ----------------------------------------------------------------------------
// A local model of the step/dir/enable logic predicts the result word for
// every accepted input word: pin levels, busy, event, step count, position
// and rate. Directed tests cover the idle rules, busy/abort rules, short
// moves with endstop and abort, rate clamps and the largest pulse settings.
// Random tests then run well-formed jog sequences with random content and
// noise under several register settings. Both stream sides idle at random,
// and one test holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;
  import sjpg_pkg::*;

  localparam int unsigned TICKS_PER_SEC = TICKS_PER_SECOND_DEF;
  localparam int unsigned LIMIT_NS      = 10_000_000;
  localparam int          HOLD_CYCLES   = 60;     // long result-side hold-off
  localparam int          FAST_RATE     = 20000;  // keeps step periods short
  localparam int          MAX_PRINTS    = 100;

  // one result word, unpacked
  typedef struct packed {
    logic                step_pin;
    logic                dir_pin;
    logic                enable_pin;
    logic                busy;
    logic [EVENT_W-1:0]  event_code;
    logic [STEPS_W-1:0]  steps_taken;
    logic [POS_W-1:0]    position;
    logic [RATE_W-1:0]   rate_hz;
  } pulse_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;   // jog_steps[15:0], endstop_level[16]
  logic [S_USER_W-1:0]   s_tuser = '0;   // cmd[3:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;        // step_pin[0], dir_pin[1], enable_pin[2],
                                         // busy_res[3], event_res[6:4],
                                         // steps_taken[22:7], position[54:23],
                                         // rate_hz[70:55]

  // bench control
  bit          idle_on  = 1'b1;  // random gaps on both sides
  bit          hold_req = 1'b0;  // asks the result side for a long hold-off
  int          mismatches = 0;
  int          words_sent = 0;
  int          words_seen = 0;
  pulse_word_t expected_words[$];

  // register shadow
  logic [TICK8_W-1:0] cfg_pulse_low = PULSE_LOW_RST;
  logic [TICK8_W-1:0] cfg_hi_min    = PULSE_HI_MIN_RST;
  logic [TICK8_W-1:0] cfg_settle    = DIR_SETTLE_RST;
  logic [RATE_W-1:0]  cfg_rate_min  = RATE_MIN_RST;
  logic [RATE_W-1:0]  cfg_rate_max  = RATE_MAX_RST;

  // motor state as the bench sees it
  logic               drv_on      = 1'b0;
  logic               dir_cw      = 1'b1;
  logic [POS_W-1:0]   pos_cnt     = '0;
  logic [RATE_W-1:0]  cur_rate    = STEP_RATE_RST;
  logic               in_move     = 1'b0;
  logic [STEPS_W-1:0] move_target = '0;
  logic [STEPS_W-1:0] move_done   = '0;
  logic               low_phase   = 1'b0;
  logic [15:0]        phase_left  = '0;
  logic [15:0]        high_len    = '0;
  logic [TICK8_W-1:0] settle_left = '0;
  logic               abort_req   = 1'b0;

  stepper_jog_pulse_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // motor model
  // --------------------------------------------------------------------------

  // the position only moves when a move ends
  function automatic logic [EVENT_W-1:0] end_move(input logic [EVENT_W-1:0] ev);
    if (dir_cw) begin
      pos_cnt = pos_cnt + {16'd0, move_done};
    end else begin
      pos_cnt = pos_cnt - {16'd0, move_done};
    end
    in_move    = 1'b0;
    low_phase  = 1'b0;
    phase_left = '0;
    abort_req  = 1'b0;
    return ev;
  endfunction

  function automatic logic [EVENT_W-1:0] begin_jog(input logic [STEPS_W-1:0] steps,
                                                   input logic endstop);
    int unsigned rate_div;
    int unsigned period;
    int unsigned hi;
    if (!drv_on) return EV_REF_DISABLED;
    if (endstop) return EV_REF_ENDSTOP;
    rate_div = (cur_rate == '0) ? 1 : cur_rate;
    period   = TICKS_PER_SEC / rate_div;
    if (period > cfg_pulse_low + cfg_hi_min) begin
      hi = period - cfg_pulse_low;
    end else begin
      hi = cfg_hi_min;
    end
    if (hi > 65535) hi = 65535;
    high_len    = hi[15:0];
    move_target = steps;
    move_done   = '0;
    low_phase   = 1'b0;
    phase_left  = '0;
    abort_req   = 1'b0;
    in_move     = 1'b1;
    if (move_target == '0) return end_move(EV_DONE);
    return EV_NONE;
  endfunction

  // one tick of a move; the step boundary checks done, endstop, abort in turn
  function automatic logic [EVENT_W-1:0] tick_move(input logic endstop, output logic lvl);
    logic [EVENT_W-1:0] ev;
    logic               stopped;
    ev      = EV_NONE;
    stopped = 1'b0;
    lvl     = 1'b1;
    if (!low_phase && phase_left == '0) begin
      if (move_done >= move_target) begin
        ev = end_move(EV_DONE);
        stopped = 1'b1;
      end else if (endstop) begin
        ev = end_move(EV_ENDSTOP_STOP);
        stopped = 1'b1;
      end else if (abort_req) begin
        ev = end_move(EV_ABORTED);
        stopped = 1'b1;
      end else begin
        low_phase  = 1'b1;
        phase_left = (cfg_pulse_low != '0) ? {8'd0, cfg_pulse_low} : 16'd1;
      end
    end
    if (!stopped) begin
      lvl = low_phase ? 1'b0 : 1'b1;
      phase_left = phase_left - 16'd1;
      if (phase_left == '0) begin
        if (low_phase) begin
          low_phase  = 1'b0;
          phase_left = (high_len != '0) ? high_len : 16'd1;
        end else begin
          move_done = move_done + 1'b1;
        end
      end
    end
    return ev;
  endfunction

  function automatic pulse_word_t predict_word(input logic [CMD_W-1:0] cmd,
                                               input logic [STEPS_W-1:0] steps,
                                               input logic endstop);
    pulse_word_t        w;
    logic               lvl;
    logic               busy_now;
    logic [RATE_W:0]    doubled;
    logic [RATE_W-1:0]  halved;
    logic [EVENT_W-1:0] ev;
    lvl      = 1'b1;
    ev       = EV_NONE;
    busy_now = in_move || settle_left != '0;
    if (cmd == CMD_TICK) begin
      // settling takes the tick before the move does
      if (settle_left != '0) begin
        settle_left = settle_left - 1'b1;
      end else if (in_move) begin
        ev = tick_move(endstop, lvl);
      end
    end else if (cmd == CMD_ABORT) begin
      if (in_move) begin
        abort_req = 1'b1;
      end else begin
        ev = EV_NO_ABORT;
      end
    end else if (cmd < CMD_ABORT && busy_now) begin
      ev = EV_IGNORED_BUSY;
    end else begin
      case (cmd)
        CMD_ENABLE:  drv_on = 1'b1;
        CMD_DISABLE: drv_on = 1'b0;
        CMD_CW: begin
          dir_cw = 1'b1;
          settle_left = cfg_settle;
        end
        CMD_CCW: begin
          dir_cw = 1'b0;
          settle_left = cfg_settle;
        end
        CMD_JOG: ev = begin_jog(steps, endstop);
        CMD_FASTER: begin
          doubled  = {cur_rate, 1'b0};
          cur_rate = (doubled < {1'b0, cfg_rate_max}) ? doubled[RATE_W-1:0] : cfg_rate_max;
        end
        CMD_SLOWER: begin
          halved   = cur_rate >> 1;
          cur_rate = (halved > cfg_rate_min) ? halved : cfg_rate_min;
        end
        default: ;  // unknown codes do nothing
      endcase
    end
    w.step_pin    = lvl;
    w.dir_pin     = ~dir_cw;
    w.enable_pin  = ~drv_on;
    w.busy        = in_move || settle_left != '0;
    w.event_code  = ev;
    w.steps_taken = move_done;
    w.position    = pos_cnt;
    w.rate_hz     = cur_rate;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t ns word %0d: %s is %0h, expected %0h", $time, words_seen, what,
               got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    pulse_word_t got;
    pulse_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.step_pin    = m_tdata[0];
      got.dir_pin     = m_tdata[1];
      got.enable_pin  = m_tdata[2];
      got.busy        = m_tdata[3];
      got.event_code  = m_tdata[6:4];
      got.steps_taken = m_tdata[22:7];
      got.position    = m_tdata[54:23];
      got.rate_hz     = m_tdata[70:55];
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", m_tdata[63:0], 0);
      end else begin
        want = expected_words.pop_front();
        if (got.step_pin !== want.step_pin)
          report_mismatch("step_pin", got.step_pin, want.step_pin);
        if (got.dir_pin !== want.dir_pin)
          report_mismatch("dir_pin", got.dir_pin, want.dir_pin);
        if (got.enable_pin !== want.enable_pin)
          report_mismatch("enable_pin", got.enable_pin, want.enable_pin);
        if (got.busy !== want.busy)
          report_mismatch("busy", got.busy, want.busy);
        if (got.event_code !== want.event_code)
          report_mismatch("event", got.event_code, want.event_code);
        if (got.steps_taken !== want.steps_taken)
          report_mismatch("steps_taken", got.steps_taken, want.steps_taken);
        if (got.position !== want.position)
          report_mismatch("position", got.position, want.position);
        if (got.rate_hz !== want.rate_hz)
          report_mismatch("rate_hz", got.rate_hz, want.rate_hz);
      end
      words_seen++;
    end
  end

  // result side: random stall bursts, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offers one word; valid stays high into the next word unless a gap is drawn
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [STEPS_W-1:0] steps,
                           input logic endstop);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, endstop, steps};
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(predict_word(cmd, steps, endstop));
    words_sent++;
  endtask

  // stop offering and let every expected word come back
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PULSE_LOW:    cfg_pulse_low = val[7:0];
      REG_PULSE_HI_MIN: cfg_hi_min    = val[7:0];
      REG_DIR_SETTLE:   cfg_settle    = val[7:0];
      REG_RATE_MIN:     cfg_rate_min  = val;
      REG_RATE_MAX:     cfg_rate_max  = val;
      default: ;
    endcase
  endtask

  // 8-bit registers get junk in the upper byte, which must be dropped
  task automatic set_config(input int low, input int hi_min, input int settle,
                            input int rate_min, input int rate_max);
    wait_idle();
    write_reg(REG_PULSE_LOW,    {8'($urandom_range(0, 255)), low[7:0]});
    write_reg(REG_PULSE_HI_MIN, {8'($urandom_range(0, 255)), hi_min[7:0]});
    write_reg(REG_DIR_SETTLE,   {8'($urandom_range(0, 255)), settle[7:0]});
    write_reg(REG_RATE_MIN,     rate_min[15:0]);
    write_reg(REG_RATE_MAX,     rate_max[15:0]);
  endtask

  // ticks (with some busy commands and endstop noise) until move and settle end;
  // a move still running after the budget gets an abort
  task automatic drive_until_idle(input int budget);
    int n;
    bit aborted;
    n = 0;
    aborted = 1'b0;
    while (in_move || settle_left != '0) begin
      n++;
      if (in_move && !aborted && n >= budget) begin
        send_word(CMD_ABORT, STEPS_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        aborted = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        send_word(CMD_W'($urandom_range(CMD_ENABLE, CMD_ABORT)),
                  STEPS_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end else begin
        send_word(CMD_TICK, STEPS_W'($urandom_range(0, 65535)), $urandom_range(0, 39) == 0);
      end
    end
  endtask

  task automatic plain_ticks(input int n, input logic endstop);
    repeat (n) send_word(CMD_TICK, 16'd0, endstop);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset state, idle ticks, unknown codes, abort with nothing moving,
  // jog refused while disabled
  task automatic test_idle_rules();
    plain_ticks(2, 1'b0);
    send_word(CMD_TICK, 16'hFFFF, 1'b1);
    for (int c = CMD_ABORT + 1; c < 16; c++) begin
      send_word(c[CMD_W-1:0], STEPS_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
    send_word(CMD_ABORT, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'hFFFF, 1'b1);
    send_word(CMD_JOG, 16'd1, 1'b0);
    send_word(CMD_SLOWER, 16'd0, 1'b0);
    send_word(CMD_FASTER, 16'd0, 1'b0);
  endtask

  // enable, refused jog on endstop, zero-step jog, busy rules during settle
  task automatic test_command_rules();
    send_word(CMD_ENABLE, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'hFFFF, 1'b1);
    send_word(CMD_JOG, 16'd0, 1'b0);
    send_word(CMD_CCW, 16'd0, 1'b0);
    send_word(CMD_FASTER, 16'd0, 1'b0);   // ignored while settling
    send_word(CMD_JOG, 16'd3, 1'b0);      // ignored while settling
    send_word(CMD_ABORT, 16'd0, 1'b0);    // nothing to abort during a settle
    while (settle_left != '0) send_word(CMD_TICK, 16'd0, 1'b0);
    send_word(CMD_CW, 16'd0, 1'b0);       // changing back to clockwise settles again
    while (settle_left != '0) send_word(CMD_TICK, 16'd0, 1'b0);
    send_word(CMD_DISABLE, 16'd0, 1'b0);
    send_word(CMD_ENABLE, 16'd0, 1'b0);
  endtask

  // shortest pulses, no settle: complete moves, endstop stop, abort, both ways
  task automatic test_short_moves();
    set_config(1, 1, 0, 16, 65535);
    while (cur_rate != 16'hFFFF) send_word(CMD_FASTER, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'd3, 1'b0);
    while (in_move) send_word(CMD_TICK, 16'd0, 1'b0);
    // endstop rises mid-move and stops it at the next step boundary
    send_word(CMD_JOG, 16'hFFFF, 1'b0);
    plain_ticks(20, 1'b0);
    while (in_move) send_word(CMD_TICK, 16'd0, 1'b1);
    // abort is held pending until the next step boundary
    send_word(CMD_JOG, 16'h8000, 1'b0);
    plain_ticks(9, 1'b0);
    send_word(CMD_ABORT, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'd1, 1'b0);
    while (in_move) send_word(CMD_TICK, 16'd0, 1'b0);
    // no settle: a direction change leaves the block free at once
    send_word(CMD_CCW, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'd2, 1'b0);
    while (in_move) send_word(CMD_TICK, 16'd0, 1'b0);
    send_word(CMD_CW, 16'd0, 1'b0);
  endtask

  // crossed rate limits and the longest pulse and settle lengths
  task automatic test_rate_extremes();
    set_config(255, 255, 255, 65535, 16);
    send_word(CMD_FASTER, 16'd0, 1'b0);
    send_word(CMD_SLOWER, 16'd0, 1'b0);
    send_word(CMD_FASTER, 16'd0, 1'b0);
    send_word(CMD_SLOWER, 16'd0, 1'b0);
    send_word(CMD_CCW, 16'd0, 1'b0);
    while (settle_left != '0) send_word(CMD_TICK, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'd1, 1'b0);
    while (in_move) send_word(CMD_TICK, 16'd0, 1'b0);
    set_config(16, 2, 3, 16, 65535);
    send_word(CMD_DISABLE, 16'd0, 1'b0);
    send_word(CMD_JOG, 16'd2, 1'b0);
    send_word(CMD_ENABLE, 16'd0, 1'b0);
  endtask

  // result side held off while a move keeps feeding words
  task automatic test_backpressure();
    wait_idle();
    while (cur_rate < FAST_RATE) send_word(CMD_FASTER, 16'd0, 1'b0);
    hold_req = 1'b1;
    send_word(CMD_JOG, 16'd2, 1'b0);
    plain_ticks(16, 1'b0);
    while (in_move) send_word(CMD_TICK, 16'd0, 1'b0);
  endtask

  // phases of random settings, each with well-formed jog sequences and noise
  task automatic test_random_moves(input int total);
    int stop_at;
    int phase_end;
    int kind;
    logic [STEPS_W-1:0] steps;
    stop_at = words_sent + total;
    while (words_sent < stop_at) begin
      set_config($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 12),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(16, 65535)
                                             : $urandom_range(16, 3000),
                 $urandom_range(FAST_RATE, 65535));
      phase_end = words_sent + 150;
      while (words_sent < phase_end && words_sent < stop_at) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send_word(CMD_W'($urandom_range(0, 15)), STEPS_W'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
        end
        drive_until_idle($urandom_range(20, 200));
        if (!drv_on && $urandom_range(0, 5) != 0) send_word(CMD_ENABLE, 16'd0, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          send_word($urandom_range(0, 1) ? CMD_CW : CMD_CCW,
                    STEPS_W'($urandom_range(0, 65535)), 1'b0);
          drive_until_idle(1000);
        end
        if ($urandom_range(0, 4) == 0) send_word(CMD_SLOWER, 16'd0, 1'b0);
        while (cur_rate < FAST_RATE) send_word(CMD_FASTER, 16'd0, 1'b0);
        if (kind == 1) begin
          send_word(CMD_DISABLE, 16'd0, 1'b0);
        end
        case ($urandom_range(0, 7))
          0:       steps = '0;
          1:       steps = STEPS_W'($urandom_range(0, 65535));
          default: steps = STEPS_W'($urandom_range(1, 4));
        endcase
        send_word(CMD_JOG, steps, $urandom_range(0, 11) == 0);
        drive_until_idle($urandom_range(20, 200));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_rules();
    test_command_rules();
    test_short_moves();
    test_rate_extremes();
    test_backpressure();
    test_random_moves(200);
    // last stretch runs at full rate on both sides
    wait_idle();
    idle_on = 1'b0;
    test_random_moves(100);
    wait_idle();
    repeat (40) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("words never returned", expected_words.size(), 0);
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sjpg_pkg.sv
design/sjpg_div.sv
design/sjpg_ctrl.sv
design/sjpg_dp.sv
design/stepper_jog_pulse_generator.sv
tb/sv/testbench.sv
